FILE: sv/accel_shake_detector_macros.svh
// Assertion macros for the shake detector.
`ifndef ACCEL_SHAKE_DETECTOR_MACROS_SVH
`define ACCEL_SHAKE_DETECTOR_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define ASD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("accel_shake_detector: same-cycle check failed");
// next-cycle implication
`define ASD_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("accel_shake_detector: next-cycle check failed");
`else
`define ASD_ASSERT_IMP(label, ante, cons)
`define ASD_ASSERT_NXT(label, ante, cons)
`endif

`endif

FILE: sv/asd_pkg.sv
// Shared widths, constants, types and microcode ROM of the shake detector.
package asd_pkg;

  localparam int unsigned TimeW     = 48;
  localparam int unsigned AccelW    = 16;
  localparam int unsigned LevelW    = 24;
  localparam int unsigned MagW      = 17;
  localparam int unsigned IntervalW = 32;
  localparam int unsigned ThreshW   = 23;
  localparam int unsigned DecayW    = 16;
  localparam int unsigned CfgW      = 32;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned PcW       = 4;
  localparam int unsigned IterW     = 4;
  localparam int unsigned RootW     = 32;
  localparam int unsigned MulAW     = LevelW + 1;
  localparam int unsigned MulBW     = DecayW + 1;
  localparam int unsigned ProdW     = MulAW + MulBW;

  localparam logic [CfgIdxW-1:0] REG_MIN_INTERVAL    = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_SHAKE_THRESHOLD = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_DECAY_FACTOR    = 2'd2;

  localparam logic [IntervalW-1:0] MIN_INTERVAL_RST = 32'd1000000;
  localparam logic [ThreshW-1:0]   THRESHOLD_RST    = 23'd2816;   // 11.0
  localparam logic [DecayW-1:0]    DECAY_RST        = 16'd58982;  // 0.9
  localparam logic [MagW-1:0]      MAG_RST          = 17'd2509;   // 9.8

  localparam logic [IterW-1:0] SQRT_LAST_ITER = 4'd15;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_WAIT,
    OP_MUL_X,
    OP_MUL_Y,
    OP_MUL_Z,
    OP_SQ_SUM,
    OP_SQRT,
    OP_MUL_LVL,
    OP_UPDATE,
    OP_EMIT
  } op_e;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_NO_WORD,
    COND_GATE_SHUT,
    COND_ITER_MORE,
    COND_OUT_BUSY,
    COND_ALWAYS
  } cond_e;

  // hold: stay on this step while true; jump: go to target when true
  typedef struct packed {
    op_e            op;
    cond_e          hold;
    cond_e          jump;
    logic [PcW-1:0] target;
  } uword_t;

  typedef struct packed {
    logic in_valid;
    logic gate_open;
    logic iter_more;
    logic out_busy;
  } seq_stat_t;

  typedef struct packed {
    logic gate_open;
    logic iter_more;
  } dp_stat_t;

  localparam logic [PcW-1:0] PC_WAIT = 4'd0;
  localparam logic [PcW-1:0] PC_EMIT = 4'd9;

  function automatic uword_t ucode(input logic [PcW-1:0] pc);
    uword_t w;
    case (pc)
      4'd0:    w = '{op: OP_WAIT,    hold: COND_NO_WORD,   jump: COND_NEVER,     target: PC_WAIT};
      4'd1:    w = '{op: OP_NOP,     hold: COND_NEVER,     jump: COND_GATE_SHUT, target: PC_EMIT};
      4'd2:    w = '{op: OP_MUL_X,   hold: COND_NEVER,     jump: COND_NEVER,     target: PC_WAIT};
      4'd3:    w = '{op: OP_MUL_Y,   hold: COND_NEVER,     jump: COND_NEVER,     target: PC_WAIT};
      4'd4:    w = '{op: OP_MUL_Z,   hold: COND_NEVER,     jump: COND_NEVER,     target: PC_WAIT};
      4'd5:    w = '{op: OP_SQ_SUM,  hold: COND_NEVER,     jump: COND_NEVER,     target: PC_WAIT};
      4'd6:    w = '{op: OP_SQRT,    hold: COND_ITER_MORE, jump: COND_NEVER,     target: PC_WAIT};
      4'd7:    w = '{op: OP_MUL_LVL, hold: COND_NEVER,     jump: COND_NEVER,     target: PC_WAIT};
      4'd8:    w = '{op: OP_UPDATE,  hold: COND_NEVER,     jump: COND_NEVER,     target: PC_WAIT};
      4'd9:    w = '{op: OP_EMIT,    hold: COND_OUT_BUSY,  jump: COND_ALWAYS,    target: PC_WAIT};
      default: w = '{op: OP_NOP,     hold: COND_NEVER,     jump: COND_ALWAYS,    target: PC_WAIT};
    endcase
    return w;
  endfunction

endpackage

FILE: sv/asd_seq.sv
// Microcode sequencer: step counter, control ROM and branch logic.
module asd_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  asd_pkg::seq_stat_t stat_i,
  output asd_pkg::uword_t    uword_o
);
  import asd_pkg::*;

  logic [PcW-1:0] pc_q, pc_d;
  uword_t         uw;

  function automatic logic cond_true(input cond_e c, input seq_stat_t s);
    logic r;
    case (c)
      COND_NEVER:     r = 1'b0;
      COND_NO_WORD:   r = !s.in_valid;
      COND_GATE_SHUT: r = !s.gate_open;
      COND_ITER_MORE: r = s.iter_more;
      COND_OUT_BUSY:  r = s.out_busy;
      COND_ALWAYS:    r = 1'b1;
      default:        r = 1'b0;
    endcase
    return r;
  endfunction

  assign uw      = ucode(pc_q);
  assign uword_o = uw;

  always_comb begin
    if (cond_true(uw.hold, stat_i)) begin
      pc_d = pc_q;
    end else if (cond_true(uw.jump, stat_i)) begin
      pc_d = uw.target;
    end else begin
      pc_d = pc_q + PcW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PC_WAIT;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

FILE: sv/asd_dp.sv
// Datapath: shared multiplier, bit-pair square root, leaky level update and state.
module asd_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  asd_pkg::op_e                    op_i,
  input  logic                            accept_i,
  input  logic [asd_pkg::TimeW-1:0]       sample_time_i,
  input  logic signed [asd_pkg::AccelW-1:0] accel_x_i,
  input  logic signed [asd_pkg::AccelW-1:0] accel_y_i,
  input  logic signed [asd_pkg::AccelW-1:0] accel_z_i,
  input  logic [asd_pkg::IntervalW-1:0]   min_interval_i,
  input  logic [asd_pkg::ThreshW-1:0]     shake_threshold_i,
  input  logic [asd_pkg::DecayW-1:0]      decay_factor_i,
  output asd_pkg::dp_stat_t               stat_o,
  output logic                            taken_o,
  output logic                            seen_o,
  output logic signed [asd_pkg::LevelW-1:0] level_o
);
  import asd_pkg::*;

  localparam int unsigned ScW    = ProdW - 16;
  localparam int unsigned DeltaW = MagW + 1;
  localparam int unsigned SumW   = ScW + 2;

  // sample word
  logic [TimeW-1:0]         time_q;
  logic signed [AccelW-1:0] x_q, y_q, z_q;
  logic                     gate_q;

  // architectural state
  logic [MagW-1:0]          mag_q;
  logic signed [LevelW-1:0] lvl_q;
  logic [TimeW-1:0]         last_q;
  logic                     taken_q, seen_q;

  // working registers
  logic signed [ProdW-1:0]  prod_q;
  logic [RootW-1:0]         acc_q, root_q;
  logic [IterW-1:0]         it_q;

  logic [TimeW-1:0]         diff;
  logic signed [MulAW-1:0]  mul_a;
  logic signed [MulBW-1:0]  mul_b;
  logic signed [ProdW-1:0]  mul_p;
  logic [RootW-1:0]         bit_val, root_plus;
  logic                     sq_ge;
  logic [ScW-1:0]           scaled;
  logic [DeltaW-1:0]        delta;
  logic [SumW-1:0]          lvl_sum;
  logic                     sat_hi, sat_lo;
  logic signed [LevelW-1:0] lvl_new;
  logic                     shake;

  assign diff = sample_time_i - last_q;

  always_comb begin
    case (op_i)
      OP_MUL_X: begin
        mul_a = {{(MulAW-AccelW){x_q[AccelW-1]}}, x_q};
        mul_b = {{(MulBW-AccelW){x_q[AccelW-1]}}, x_q};
      end
      OP_MUL_Y: begin
        mul_a = {{(MulAW-AccelW){y_q[AccelW-1]}}, y_q};
        mul_b = {{(MulBW-AccelW){y_q[AccelW-1]}}, y_q};
      end
      OP_MUL_Z: begin
        mul_a = {{(MulAW-AccelW){z_q[AccelW-1]}}, z_q};
        mul_b = {{(MulBW-AccelW){z_q[AccelW-1]}}, z_q};
      end
      OP_MUL_LVL: begin
        mul_a = {lvl_q[LevelW-1], lvl_q};
        mul_b = {1'b0, decay_factor_i};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // one restoring step of the digit-pair square root
  assign bit_val   = RootW'(1) << {it_q, 1'b0};
  assign root_plus = root_q + bit_val;
  assign sq_ge     = acc_q >= root_plus;

  // floor(level*decay/65536) is the arithmetic shift of the product
  assign scaled  = prod_q[ProdW-1:16];
  assign delta   = {1'b0, root_q[MagW-1:0]} - {1'b0, mag_q};
  assign lvl_sum = {{(SumW-ScW){scaled[ScW-1]}}, scaled}
                 + {{(SumW-DeltaW){delta[DeltaW-1]}}, delta};
  assign sat_hi  = !lvl_sum[SumW-1] && (lvl_sum[SumW-2:LevelW-1] != '0);
  assign sat_lo  = lvl_sum[SumW-1] && (lvl_sum[SumW-2:LevelW-1] != '1);

  always_comb begin
    if (sat_hi) begin
      lvl_new = {1'b0, {(LevelW-1){1'b1}}};
    end else if (sat_lo) begin
      lvl_new = {1'b1, {(LevelW-1){1'b0}}};
    end else begin
      lvl_new = lvl_sum[LevelW-1:0];
    end
  end

  assign shake = lvl_new > $signed({1'b0, shake_threshold_i});

  // sample word and working registers
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      time_q <= sample_time_i;
      x_q    <= accel_x_i;
      y_q    <= accel_y_i;
      z_q    <= accel_z_i;
      gate_q <= diff > {{(TimeW-IntervalW){1'b0}}, min_interval_i};
    end
    case (op_i)
      OP_MUL_X, OP_MUL_LVL: begin
        prod_q <= mul_p;
      end
      OP_MUL_Y: begin
        prod_q <= mul_p;
        acc_q  <= prod_q[RootW-1:0];
      end
      OP_MUL_Z: begin
        prod_q <= mul_p;
        acc_q  <= acc_q + prod_q[RootW-1:0];
      end
      OP_SQ_SUM: begin
        acc_q  <= acc_q + prod_q[RootW-1:0];
        root_q <= '0;
        it_q   <= SQRT_LAST_ITER;
      end
      OP_SQRT: begin
        if (sq_ge) begin
          acc_q  <= acc_q - root_plus;
          root_q <= (root_q >> 1) + bit_val;
        end else begin
          root_q <= root_q >> 1;
        end
        it_q <= it_q - IterW'(1);
      end
      default: begin
      end
    endcase
  end

  // detector state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mag_q   <= MAG_RST;
      lvl_q   <= '0;
      last_q  <= '0;
      taken_q <= 1'b0;
      seen_q  <= 1'b0;
    end else if (accept_i) begin
      taken_q <= 1'b0;
      seen_q  <= 1'b0;
    end else if (op_i == OP_UPDATE) begin
      mag_q   <= root_q[MagW-1:0];
      lvl_q   <= lvl_new;
      taken_q <= 1'b1;
      seen_q  <= shake;
      if (shake) begin
        last_q <= time_q;
      end
    end
  end

  assign stat_o.gate_open = gate_q;
  assign stat_o.iter_more = (it_q != '0);
  assign taken_o          = taken_q;
  assign seen_o           = seen_q;
  assign level_o          = lvl_q;

endmodule

FILE: sv/accel_shake_detector.sv
// Top level of the accelerometer shake detector: config registers, output register.
// A new word is taken only after the previous result is loaded into the output
// register. A shut interval gate skips the multiplies and the 16-step square root
// loop; the emit step holds while the output register is stalled.
// Reset (async, active low): sequencer to wait step, magnitude 9.8, level 0,
// last shake time 0, registers to their defaults, output register empty.
`include "accel_shake_detector_macros.svh"

module accel_shake_detector (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // sample channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [asd_pkg::TimeW-1:0]         sample_time_i,
  input  logic signed [asd_pkg::AccelW-1:0] accel_x_i,
  input  logic signed [asd_pkg::AccelW-1:0] accel_y_i,
  input  logic signed [asd_pkg::AccelW-1:0] accel_z_i,
  // result channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              sample_taken_o,
  output logic                              shake_seen_o,
  output logic signed [asd_pkg::LevelW-1:0] shake_level_o,
  // config write port
  input  logic                              cfg_we_i,
  input  logic [asd_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [asd_pkg::CfgW-1:0]          cfg_wdata_i
);
  import asd_pkg::*;

  // config registers
  logic [IntervalW-1:0] interval_q;
  logic [ThreshW-1:0]   thr_q;
  logic [DecayW-1:0]    decay_q;

  // output register
  logic                     out_valid_q;
  logic                     taken_q, seen_q;
  logic signed [LevelW-1:0] level_q;

  uword_t    uw;
  seq_stat_t seq_stat;
  dp_stat_t  dp_stat;
  logic      in_accept;
  logic      out_busy;
  logic      out_load;
  logic      dp_taken, dp_seen;
  logic signed [LevelW-1:0] dp_level;

  // a word is taken only on the wait step of the program
  assign in_stall_o = (uw.op != OP_WAIT);
  assign in_accept  = in_valid_i && !in_stall_o;

  // the emit step holds while the previous result is still stalled
  assign out_busy = out_valid_q && out_stall_i;
  assign out_load = (uw.op == OP_EMIT) && !out_busy;

  assign seq_stat.in_valid  = in_valid_i;
  assign seq_stat.gate_open = dp_stat.gate_open;
  assign seq_stat.iter_more = dp_stat.iter_more;
  assign seq_stat.out_busy  = out_busy;

  asd_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .stat_i  (seq_stat),
    .uword_o (uw)
  );

  asd_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .op_i              (uw.op),
    .accept_i          (in_accept),
    .sample_time_i     (sample_time_i),
    .accel_x_i         (accel_x_i),
    .accel_y_i         (accel_y_i),
    .accel_z_i         (accel_z_i),
    .min_interval_i    (interval_q),
    .shake_threshold_i (thr_q),
    .decay_factor_i    (decay_q),
    .stat_o            (dp_stat),
    .taken_o           (dp_taken),
    .seen_o            (dp_seen),
    .level_o           (dp_level)
  );

  // config writes; an index past the list is dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= MIN_INTERVAL_RST;
      thr_q      <= THRESHOLD_RST;
      decay_q    <= DECAY_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MIN_INTERVAL:    interval_q <= cfg_wdata_i[IntervalW-1:0];
        REG_SHAKE_THRESHOLD: thr_q      <= cfg_wdata_i[ThreshW-1:0];
        REG_DECAY_FACTOR:    decay_q    <= cfg_wdata_i[DecayW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      taken_q <= dp_taken;
      seen_q  <= dp_seen;
      level_q <= dp_level;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sample_taken_o = taken_q;
  assign shake_seen_o   = seen_q;
  assign shake_level_o  = level_q;

  // a shake is only reported for a sample that went through
  `ASD_ASSERT_IMP(a_seen_needs_taken, out_valid_o && shake_seen_o, sample_taken_o)
  // a reported shake level lies above the threshold
  `ASD_ASSERT_IMP(a_seen_above_thr, out_valid_o && shake_seen_o, shake_level_o > $signed({1'b0, thr_q}))
  // one word in flight: the port closes right after an accept
  `ASD_ASSERT_NXT(a_one_in_flight, in_accept, in_stall_o)
  // a loaded result shows up on the port
  `ASD_ASSERT_NXT(a_load_shows, out_load, out_valid_o)

endmodule

FILE: dv/tb_accel_shake_detector.sv
`timescale 1ns / 1ps
// Self-checking testbench for accel_shake_detector: directed corners, then random phases.
module tb_accel_shake_detector;
  import asd_pkg::*;

  localparam logic [31:0] GATE_DEF      = 32'd1000000;
  localparam logic [22:0] THRESH_DEF    = 23'd2816;
  localparam logic [15:0] DECAY_DEF     = 16'd58982;
  localparam logic [16:0] REST_MAG      = 17'd2509;   // 9.8 m/s^2 in Q8.8
  localparam int          SETTLE_CYCLES = 30;
  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int          PHASE_WORDS   = 166;

  typedef struct packed {
    logic              taken;
    logic              seen;
    logic signed [23:0] level;
  } shake_report_t;

  // Tracks gate, magnitude, leaky level and last shake time; holds the
  // reports still owed by the block.
  class shake_tracker;
    logic [31:0]        min_gap;
    logic [22:0]        threshold;
    logic [15:0]        decay;
    logic [16:0]        mag;
    logic signed [23:0] level;
    logic [47:0]        last_shake;
    shake_report_t      owed_reports[$];
    int                 errors;

    function new();
      min_gap    = GATE_DEF;
      threshold  = THRESH_DEF;
      decay      = DECAY_DEF;
      mag        = REST_MAG;
      level      = '0;
      last_shake = '0;
      errors     = 0;
    endfunction

    function int pending();
      return owed_reports.size();
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
      case (idx)
        REG_MIN_INTERVAL:    min_gap   = data;
        REG_SHAKE_THRESHOLD: threshold = data[22:0];
        REG_DECAY_FACTOR:    decay     = data[15:0];
        default: ;  // unmapped index, write dropped
      endcase
    endfunction

    // floor square root, one result bit at a time from the top
    function logic [16:0] floor_root(logic [31:0] v);
      logic [16:0]     r;
      longint unsigned cand;
      r = '0;
      for (int b = 16; b >= 0; b--) begin
        cand = longint'(r) | (64'd1 << b);
        if (cand * cand <= longint'(v)) r = cand[16:0];
      end
      return r;
    endfunction

    function void take_sample(logic [47:0] t, logic signed [15:0] ax,
                              logic signed [15:0] ay, logic signed [15:0] az);
      shake_report_t r;
      logic [47:0]   since;
      longint        sum;
      logic [16:0]   root;
      longint        nxt;
      since   = t - last_shake;
      r.taken = 1'b0;
      r.seen  = 1'b0;
      if (since > {16'd0, min_gap}) begin
        sum  = longint'(ax) * ax + longint'(ay) * ay + longint'(az) * az;
        root = floor_root(sum[31:0]);
        // >>> on a signed product floors toward minus infinity
        nxt  = ((longint'(level) * longint'(decay)) >>> 16) + longint'(root) - longint'(mag);
        if (nxt > 64'sd8388607) nxt = 64'sd8388607;
        if (nxt < -64'sd8388608) nxt = -64'sd8388608;
        mag     = root;
        level   = nxt[23:0];
        r.taken = 1'b1;
        if (nxt > longint'(threshold)) begin
          last_shake = t;
          r.seen     = 1'b1;
        end
      end
      r.level = level;
      owed_reports.push_back(r);
    endfunction

    function void complain(string field, logic signed [63:0] want, logic signed [63:0] got);
      errors++;
      $display("%0t: %s expected %0d got %0d", $time, field, want, got);
    endfunction

    function void match_report(logic taken, logic seen, logic signed [23:0] lvl);
      shake_report_t want;
      if (owed_reports.size() == 0) begin
        complain("unexpected word, shake_level", 0, lvl);
        return;
      end
      want = owed_reports.pop_front();
      if (taken !== want.taken) complain("sample_taken", want.taken, taken);
      if (seen !== want.seen) complain("shake_seen", want.seen, seen);
      if (lvl !== want.level) complain("shake_level", want.level, lvl);
    endfunction
  endclass

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic [TimeW-1:0]         sample_time_i = '0;
  logic signed [AccelW-1:0] accel_x_i = '0;
  logic signed [AccelW-1:0] accel_y_i = '0;
  logic signed [AccelW-1:0] accel_z_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic                     sample_taken_o;
  logic                     shake_seen_o;
  logic signed [LevelW-1:0] shake_level_o;
  logic                     cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]       cfg_idx_i = '0;
  logic [CfgW-1:0]          cfg_wdata_i = '0;

  shake_tracker tracker = new();
  bit           idling = 1'b1;   // random gaps on both channels when set
  int           stall_left = 0;
  int           quiet_cycles = 0;
  logic [47:0]  last_sent = '0;

  accel_shake_detector u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .sample_time_i (sample_time_i),
    .accel_x_i     (accel_x_i),
    .accel_y_i     (accel_y_i),
    .accel_z_i     (accel_z_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .sample_taken_o(sample_taken_o),
    .shake_seen_o  (shake_seen_o),
    .shake_level_o (shake_level_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #6 clk_i = ~clk_i;

  // Observe register writes and both handshakes at the rising edge. A result
  // leaving in the same cycle as a word arrives belongs to an older word, so
  // it is matched first.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) tracker.set_reg(cfg_idx_i, cfg_wdata_i);
      if (out_valid_o && !out_stall_i)
        tracker.match_report(sample_taken_o, shake_seen_o, shake_level_o);
      if (in_valid_i && !in_stall_o)
        tracker.take_sample(sample_time_i, accel_x_i, accel_y_i, accel_z_i);
    end
  end

  // Result-side back-pressure: stall bursts of random length, started only while idling is set.
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (idling && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 12);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Watchdog: nothing moving on any port for too long ends the run.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired", $time);
      $display("tb_accel_shake_detector: errors");
      $finish;
    end
  end

  // Present one sample word, with an optional gap first; returns after the
  // edge that accepts it. Valid stays high so the next word can follow at once.
  task automatic push_sample(input logic [47:0] t, input logic signed [15:0] ax,
                             input logic signed [15:0] ay, input logic signed [15:0] az);
    @(negedge clk_i);
    if (idling && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end
    sample_time_i <= t;
    accel_x_i     <= ax;
    accel_y_i     <= ay;
    accel_z_i     <= az;
    in_valid_i    <= 1'b1;
    last_sent = t;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Stop sending, wait for every owed result, then let the pipeline drain.
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic set_regs(input logic [31:0] gap, input logic [31:0] thr,
                          input logic [31:0] dec);
    write_reg(REG_MIN_INTERVAL, gap);
    write_reg(REG_SHAKE_THRESHOLD, thr);
    write_reg(REG_DECAY_FACTOR, dec);
  endtask

  function automatic logic signed [15:0] corner_axis();
    case ($urandom_range(0, 3))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return 16'sh0000;
      default: return 16'shFFFF;
    endcase
  endfunction

  // Mostly gate-passing timestamps, many right on the gate edge, some inside the hold-off,
  // some behind the last shake (wrap), some shortly after the last word sent and some fully random.
  function automatic logic [47:0] pick_time();
    logic [47:0] edge_t;
    edge_t = tracker.last_shake + {16'd0, tracker.min_gap};
    case ($urandom_range(0, 9))
      0:       return edge_t + 48'($urandom_range(0, 4)) - 48'd2;
      1, 2, 3, 4, 5:
               return edge_t + 48'($urandom_range(1, 200000));
      6:       return tracker.last_shake + 48'($urandom_range(0, tracker.min_gap));
      7:       return 48'({$urandom, $urandom});
      8:       return tracker.last_shake - 48'($urandom_range(1, 1000));
      default: return last_sent + 48'($urandom_range(0, 2000));
    endcase
  endfunction

  // Device at rest with noise, shaking, arbitrary, or axis extremes.
  task automatic pick_accel(output logic signed [15:0] ax, output logic signed [15:0] ay,
                            output logic signed [15:0] az);
    int mode;
    mode = $urandom_range(0, 9);
    if (mode < 5) begin
      ax = 16'(int'($urandom_range(0, 200)) - 100);
      ay = 16'(int'($urandom_range(0, 200)) - 100);
      az = 16'(int'($urandom_range(0, 400)) - 200 + 2509);
    end else if (mode < 7) begin
      ax = 16'(int'($urandom_range(0, 16000)) - 8000);
      ay = 16'(int'($urandom_range(0, 16000)) - 8000);
      az = 16'(int'($urandom_range(0, 16000)) - 8000);
    end else if (mode < 9) begin
      ax = 16'($urandom);
      ay = 16'($urandom);
      az = 16'($urandom);
    end else begin
      ax = corner_axis();
      ay = corner_axis();
      az = corner_axis();
    end
  endtask

  task automatic random_phase(input int count);
    logic [47:0]        t;
    logic signed [15:0] ax, ay, az;
    repeat (count) begin
      t = pick_time();
      pick_accel(ax, ay, az);
      push_sample(t, ax, ay, az);
    end
  endtask

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, reset register values first.
    push_sample(48'd0, 16'sd0, 16'sd0, 16'sd0);             // diff zero, gate shut
    push_sample(48'd1000000, 16'sd0, 16'sd0, 16'sd2509);    // diff equals interval, shut
    push_sample(48'd1000001, 16'sd0, 16'sd0, 16'sd2509);    // at rest, no change
    push_sample(48'd1000002, 16'sd0, 16'sd0, 16'sd0);       // free fall, level goes negative
    push_sample(48'd1000003, 16'sh8000, 16'sh8000, 16'sh8000);  // largest magnitude
    push_sample(48'd1500000, 16'sd100, 16'sd100, 16'sd100); // inside hold-off if it shook
    push_sample(48'd2000004, 16'sh7FFF, 16'sh8000, 16'sd1);
    push_sample(48'd0, 16'sd100, -16'sd100, 16'sd2509);     // timestamp behind last shake
    push_sample(48'hFFFF_FFFF_FFFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    push_sample(48'h8000_0000_0000, -16'sd1, -16'sd1, -16'sd1);
    settle();

    // No hold-off, zero threshold, no memory in the level.
    set_regs(32'd0, 32'd0, 32'd0);
    write_reg(2'd3, 32'hFFFF_FFFF);                          // unmapped index
    push_sample(tracker.last_shake, 16'sd5, 16'sd5, 16'sd5);        // same time, shut
    push_sample(tracker.last_shake + 48'd1, 16'sd0, 16'sd0, 16'sd2509);
    push_sample(tracker.last_shake + 48'd2, 16'sd0, 16'sd0, 16'sd2600);
    push_sample(tracker.last_shake + 48'd1, 16'sd0, 16'sd0, 16'sd2600);
    settle();

    // Longest hold-off, unreachable threshold, slowest decay.
    set_regs(32'hFFFF_FFFF, 32'h007F_FFFF, 32'h0000_FFFF);
    push_sample(tracker.last_shake + 48'hFFFF_FFFF, 16'sd1, 16'sd2, 16'sd3);
    push_sample(tracker.last_shake + 48'h1_0000_0000, 16'sh8000, 16'sh7FFF, 16'sh8000);
    push_sample(tracker.last_shake + 48'h1_0000_0001, 16'sd0, 16'sd0, 16'sd0);
    push_sample(tracker.last_shake + 48'h1_0000_0002, 16'sd3, -16'sd7, 16'sd1);
    push_sample(tracker.last_shake + 48'h1_0000_0003, 16'sd0, 16'sd0, 16'sd0);

    // Random phases, each under its own register setting.
    for (int p = 0; p < 8; p++) begin
      settle();
      case (p)
        0: set_regs(GATE_DEF, THRESH_DEF, DECAY_DEF);
        1: set_regs(32'd0, 32'd0, 32'd0);
        2: set_regs(32'hFFFF_FFFF, 32'h007F_FFFF, 32'h0000_FFFF);
        3: set_regs(32'd1000, 32'd1500, 32'd32768);
        4: set_regs($urandom_range(0, 5000000), $urandom_range(0, 20000),
                    $urandom_range(0, 65535));
        5: set_regs(32'd500, 32'd5000, 32'd65535);
        6: begin
          // stray bits above each register's width must be dropped
          set_regs($urandom, $urandom, $urandom);
          write_reg(2'd3, $urandom);
        end
        default: set_regs(32'd250000, THRESH_DEF, DECAY_DEF);
      endcase
      idling = (p != 3 && p != 7);  // quiet stretch mid-run, and none at the tail
      random_phase(PHASE_WORDS);
    end

    settle();
    if (tracker.errors == 0 && tracker.pending() == 0)
      $display("tb_accel_shake_detector: clean");
    else
      $display("tb_accel_shake_detector: errors");
    $finish;
  end

endmodule
